/* sv/lfp_pkg.sv */
// Shared types and constants for the lidar frame parser.
package lfp_pkg;

    // Input transaction: command code and received byte
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } lfp_in_t;

    // Result transaction
    typedef struct packed {
        logic        kind;
        logic [7:0]  upload_byte;
        logic [15:0] distance;
    } lfp_out_t;

    // Command codes
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_UPLOAD = 1'b0;
    localparam logic KIND_FAIL   = 1'b1;

    // Frame positions
    localparam logic [3:0] POS_HUNT        = 4'd0;
    localparam logic [3:0] POS_HDR2        = 4'd1;
    localparam logic [3:0] POS_DIST_LO     = 4'd2;
    localparam logic [3:0] POS_DIST_HI     = 4'd3;
    localparam logic [3:0] POS_EXTRA_FIRST = 4'd4;
    localparam logic [3:0] POS_EXTRA_LAST  = 4'd7;
    localparam logic [3:0] POS_CHECK       = 4'd8;

    localparam logic [7:0]  HEADER_BYTE    = 8'h59;
    localparam logic [7:0]  SAT_BYTE       = 8'hFF;
    localparam logic [15:0] INTERVAL_RESET = 16'd200;
    localparam logic [15:0] ELAPSED_MAX    = 16'hFFFF;

endpackage

/* sv/lfp_parser.sv */
// Frame parser: header hunt, checksum, elapsed-time counter and result build.
module lfp_parser import lfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        proc_en,
    input  lfp_in_t     item,
    input  logic [15:0] interval,
    output logic        res_valid,
    output lfp_out_t    res
);

    logic [3:0]  pos_reg,     pos_next;
    logic [7:0]  sum_reg,     sum_next;
    logic [7:0]  dist_lo_reg, dist_lo_next;
    logic [7:0]  dist_hi_reg, dist_hi_next;
    logic [15:0] elapsed_reg, elapsed_next;

    logic [3:0]  pos_eff;
    logic [15:0] frame_dist;
    logic [7:0]  sum_add;

    assign pos_eff    = (pos_reg > POS_CHECK) ? POS_HUNT : pos_reg;
    assign frame_dist = {dist_hi_reg, dist_lo_reg};
    assign sum_add    = sum_reg + item.rx_byte;

    // Next state and result for the transaction being processed
    always_comb begin
        pos_next         = pos_reg;
        sum_next         = sum_reg;
        dist_lo_next     = dist_lo_reg;
        dist_hi_next     = dist_hi_reg;
        elapsed_next     = elapsed_reg;
        res_valid        = 1'b0;
        res.kind         = KIND_FAIL;
        res.upload_byte  = 8'd0;
        res.distance     = frame_dist;
        if (proc_en) begin
            if (item.cmd == CMD_TICK) begin
                if (elapsed_reg != ELAPSED_MAX) begin
                    elapsed_next = elapsed_reg + 16'd1;
                end
            end else begin
                unique case (pos_eff) inside
                    POS_HUNT: begin
                        pos_next = POS_HUNT;
                        if (item.rx_byte == HEADER_BYTE) begin
                            sum_next = item.rx_byte;
                            pos_next = POS_HDR2;
                        end
                    end
                    POS_HDR2: begin
                        if (item.rx_byte == HEADER_BYTE) begin
                            sum_next = sum_add;
                            pos_next = POS_DIST_LO;
                        end else begin
                            pos_next = POS_HUNT;
                        end
                    end
                    POS_DIST_LO, POS_DIST_HI, [POS_EXTRA_FIRST:POS_EXTRA_LAST]: begin
                        if (pos_eff == POS_DIST_LO) begin
                            dist_lo_next = item.rx_byte;
                        end
                        if (pos_eff == POS_DIST_HI) begin
                            dist_hi_next = item.rx_byte;
                        end
                        sum_next = sum_add;
                        pos_next = pos_eff + 4'd1;
                    end
                    POS_CHECK: begin
                        pos_next = POS_HUNT;
                        if (item.rx_byte != sum_reg) begin
                            res_valid = 1'b1;
                        end else if (elapsed_reg >= interval) begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_UPLOAD;
                            res.upload_byte = (dist_hi_reg != 8'd0) ? SAT_BYTE : dist_lo_reg;
                            elapsed_next    = 16'd0;
                        end
                    end
                    default: begin
                        pos_next = POS_HUNT;
                    end
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= POS_HUNT;
            sum_reg     <= 8'd0;
            dist_lo_reg <= 8'd0;
            dist_hi_reg <= 8'd0;
            elapsed_reg <= 16'd0;
        end else begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            dist_lo_reg <= dist_lo_next;
            dist_hi_reg <= dist_hi_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

/* sv/lidar_frame_parser_rate_limited.sv */
// Top level: input register, frame parser, result register and interval register.
//
//  channel   ports                       direction  payload
//  input     s_valid s_ready s_data      in         lfp_in_t  (cmd, rx_byte)
//  result    m_valid m_ready m_data      out        lfp_out_t (kind, upload_byte, distance)
//  config    cfg_valid cfg_ready cfg_data in        upload_interval_ms, 16 bits
//
// One transaction per cycle while no result waits on m_ready; a result is registered in
// the result register after its transaction has passed the input register and the parser.
// Synchronous active-low reset clears the frame state, the elapsed count and
// both valid flags; the interval register resets to 200.
// A result waiting on m_ready stops the parser; with the input register also
// full, s_ready drops in that same cycle. cfg_ready is always high.
module lidar_frame_parser_rate_limited import lfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  lfp_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output lfp_out_t    m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg;
    lfp_in_t     in_data_reg;
    logic        out_valid_reg, out_valid_next;
    lfp_out_t    out_data_reg;
    logic [15:0] interval_reg;

    logic        advance;
    logic        proc_en;
    logic        res_valid;
    lfp_out_t    res;

    // Pipeline flow control
    assign advance   = !out_valid_reg || m_ready;
    assign proc_en   = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // Interval register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            interval_reg <= cfg_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    lfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .proc_en   (proc_en),
        .item      (in_data_reg),
        .interval  (interval_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    assign out_valid_next = advance ? res_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_data_reg <= res;
        end
    end

    // Checks
    a_upload_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_UPLOAD) |->
        (m_data.upload_byte == ((m_data.distance > 16'd255) ? SAT_BYTE
                                                           : m_data.distance[7:0])))
        else $error("upload byte does not match saturated distance");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.kind == KIND_FAIL) |-> (m_data.upload_byte == 8'd0))
        else $error("failure result carries a nonzero upload byte");

    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("stalled input transaction lost");

    a_res_only_check: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (proc_en && in_data_reg.cmd == CMD_BYTE))
        else $error("result raised without a processed byte");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the rate-limited lidar frame parser.
`timescale 1ns / 100ps

module testbench;
    import lfp_pkg::*;

    localparam int RESET_CYCLES  = 8;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PHASE_ITEMS   = 110;
    localparam int LARGE_TICKS   = 30;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    lfp_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    lfp_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Predicted parser state, mirrors the block after reset
    logic [3:0]  parse_pos      = POS_HUNT;
    logic [7:0]  frame_sum      = '0;
    logic [7:0]  range_lo       = '0;
    logic [7:0]  range_hi       = '0;
    logic [15:0] elapsed_count  = '0;
    logic [15:0] interval_ms    = INTERVAL_RESET;

    lfp_out_t    frame_results_due[$];

    int          error_count = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    bit          send_gaps_on    = 1'b1;
    bit          ready_stalls_on = 1'b1;
    bit          ticks_in_frames = 1'b0;
    bit          hold_request    = 1'b0;

    lidar_frame_parser_rate_limited dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Advance the predicted parser by one accepted transaction
    task automatic parse_lidar_item(input lfp_in_t item);
        lfp_out_t    res;
        logic [15:0] range_mm;
        if (item.cmd == CMD_TICK) begin
            if (elapsed_count != ELAPSED_MAX)
                elapsed_count++;
            return;
        end
        if (parse_pos > POS_CHECK)
            parse_pos = POS_HUNT;
        case (parse_pos)
            POS_HUNT: begin
                if (item.rx_byte == HEADER_BYTE) begin
                    frame_sum = item.rx_byte;
                    parse_pos = POS_HDR2;
                end
            end
            POS_HDR2: begin
                if (item.rx_byte == HEADER_BYTE) begin
                    frame_sum = frame_sum + item.rx_byte;
                    parse_pos = POS_DIST_LO;
                end else begin
                    parse_pos = POS_HUNT;
                end
            end
            POS_CHECK: begin
                parse_pos = POS_HUNT;
                range_mm = {range_hi, range_lo};
                res.distance = range_mm;
                if (item.rx_byte != frame_sum) begin
                    res.kind = KIND_FAIL;
                    res.upload_byte = '0;
                    frame_results_due.push_back(res);
                end else if (elapsed_count >= interval_ms) begin
                    elapsed_count = '0;
                    res.kind = KIND_UPLOAD;
                    res.upload_byte = (range_mm > {8'd0, SAT_BYTE}) ? SAT_BYTE : range_mm[7:0];
                    frame_results_due.push_back(res);
                end
            end
            default: begin
                if (parse_pos == POS_DIST_LO)
                    range_lo = item.rx_byte;
                else if (parse_pos == POS_DIST_HI)
                    range_hi = item.rx_byte;
                frame_sum = frame_sum + item.rx_byte;
                parse_pos = parse_pos + 4'd1;
            end
        endcase
    endtask

    // Offer one transaction; valid stays high after acceptance until the next call
    task automatic send_item(input lfp_in_t item);
        int gap;
        gap = send_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!(s_valid && s_ready));
        parse_lidar_item(item);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        lfp_in_t item;
        item.cmd = CMD_BYTE;
        item.rx_byte = b;
        send_item(item);
    endtask

    task automatic send_tick();
        lfp_in_t item;
        item.cmd = CMD_TICK;
        item.rx_byte = 8'($urandom_range(0, 255));
        send_item(item);
    endtask

    // Full nine-byte frame, random extra bytes, optionally a wrong checksum
    task automatic send_frame(input logic [15:0] range_mm, input bit bad_sum);
        logic [7:0] frame_bytes [0:8];
        logic [7:0] sum;
        int k;
        frame_bytes[0] = HEADER_BYTE;
        frame_bytes[1] = HEADER_BYTE;
        frame_bytes[2] = range_mm[7:0];
        frame_bytes[3] = range_mm[15:8];
        for (k = 4; k < 8; k++)
            frame_bytes[k] = 8'($urandom_range(0, 255));
        sum = '0;
        for (k = 0; k < 8; k++)
            sum = sum + frame_bytes[k];
        frame_bytes[8] = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        for (k = 0; k < 9; k++) begin
            if (ticks_in_frames && $urandom_range(0, 9) == 0)
                send_tick();
            send_byte(frame_bytes[k]);
        end
    endtask

    // Stop offering and wait until every predicted result has been seen
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Interval register write; only called with the block drained
    task automatic write_interval(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        interval_ms = value;
        cfg_valid <= 1'b0;
    endtask

    // Reset interval, early good frame, checksum failure, hunt noise, bad second header
    task automatic test_early_frames();
        send_frame(16'h0123, 1'b0);
        send_frame(16'hFFFF, 1'b1);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEADER_BYTE);
        send_byte(8'h58);
        wait_for_drain();
    endtask

    // Zero interval: every good frame goes up, saturation at 255
    task automatic test_zero_interval();
        send_gaps_on = 1'b0;
        ready_stalls_on = 1'b0;
        write_interval(16'd0);
        send_frame(16'h00FF, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        wait_for_drain();
        send_gaps_on = 1'b1;
        ready_stalls_on = 1'b1;
    endtask

    // Upload gated by ticks since the last upload
    task automatic test_interval_gate();
        write_interval(16'd2);
        send_frame(16'h0100, 1'b0);
        send_tick();
        send_tick();
        send_frame(16'h0000, 1'b0);
        wait_for_drain();
    endtask

    // Receiver holds off while frames keep coming, so the input stalls
    task automatic test_result_backpressure();
        int n;
        write_interval(16'd0);
        send_gaps_on = 1'b0;
        hold_request = 1'b1;
        for (n = 0; n < 6; n++)
            send_frame(16'($urandom_range(0, 65535)), n[0]);
        wait_for_drain();
        send_gaps_on = 1'b1;
    endtask

    // Several interval settings, each phase ending with a full drain
    task automatic test_random_traffic();
        int phase;
        int phase_start;
        int r;
        int n;
        int burst;
        logic [15:0] range_mm;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_interval(16'd0);
                1: write_interval(16'd1);
                2: write_interval(16'd4);
                3: write_interval(16'($urandom_range(0, 30)));
                4: write_interval(INTERVAL_RESET);
                default: write_interval(16'd0);
            endcase
            // one phase runs with no idling on either side
            send_gaps_on    = (phase != 2);
            ready_stalls_on = (phase != 2);
            ticks_in_frames = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    case ($urandom_range(0, 3))
                        0: range_mm = 16'($urandom_range(0, 255));
                        1: range_mm = 16'($urandom_range(254, 257));
                        default: range_mm = 16'($urandom_range(0, 65535));
                    endcase
                    send_frame(range_mm, 1'b0);
                end else if (r < 70) begin
                    send_frame(16'($urandom_range(0, 65535)), 1'b1);
                end else if (r < 78) begin
                    // truncated frame or broken second header
                    send_byte(HEADER_BYTE);
                    if ($urandom_range(0, 1) == 0) begin
                        send_byte(8'($urandom_range(0, 255)));
                    end else begin
                        send_byte(HEADER_BYTE);
                        burst = $urandom_range(1, 6);
                        for (n = 0; n < burst; n++)
                            send_byte(8'($urandom_range(0, 255)));
                    end
                end else if (r < 88) begin
                    burst = $urandom_range(1, (phase == 4) ? 60 : 8);
                    for (n = 0; n < burst; n++)
                        send_tick();
                end else begin
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
            wait_for_drain();
        end
        ticks_in_frames = 1'b0;
        send_gaps_on    = 1'b1;
        ready_stalls_on = 1'b1;
    endtask

    // Largest interval: good frames are held back, failures still come out
    task automatic test_large_interval();
        int n;
        write_interval(ELAPSED_MAX);
        send_frame(16'h1234, 1'b0);
        for (n = 0; n < LARGE_TICKS; n++)
            send_tick();
        send_frame(16'h0042, 1'b0);
        send_frame(16'h0042, 1'b1);
        wait_for_drain();
    endtask

    // Result side ready: random stalls, plus one long hold when requested
    initial begin : result_receiver
        int stall;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (ready_stalls_on && $urandom_range(0, 3) == 0) begin
                stall = 1 + pick_gap();
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : result_checker
        lfp_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (frame_results_due.size() == 0) begin
                report_error($sformatf("unexpected result %h", m_data));
            end else begin
                want = frame_results_due.pop_front();
                if (m_data.kind !== want.kind)
                    report_error($sformatf("kind got %b expected %b", m_data.kind, want.kind));
                if (m_data.upload_byte !== want.upload_byte)
                    report_error($sformatf("upload_byte got %h expected %h",
                                           m_data.upload_byte, want.upload_byte));
                if (m_data.distance !== want.distance)
                    report_error($sformatf("distance got %h expected %h",
                                           m_data.distance, want.distance));
            end
        end
    end

    // Watchdog: too long without any transaction on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        test_early_frames();
        test_zero_interval();
        test_interval_gate();
        test_result_backpressure();
        test_random_traffic();
        test_large_interval();

        wait_for_drain();
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (frame_results_due.size() != 0)
            report_error($sformatf("%0d results never arrived", frame_results_due.size()));
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
